// ----- rtl/core/hsvrgb_pkg.sv -----
package hsvrgb_pkg;

  // input request: one pixel in hsv form
  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
  } hsv_t;

  // output request: one pixel in rgb form
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  // 60 degree sectors of the colour wheel
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // register stages in the converter pipeline
  localparam int NSTAGE = 7;

  // one sector in tenths of a degree
  localparam logic [9:0]  HUE_SECTOR = 10'd600;
  // floor(2^22 / 600), underestimates hue / 600 by at most one
  localparam logic [12:0] HUE_RECIP  = 13'd6990;
  // q * 43 >> 8 equals q / 6 for q up to 127
  localparam logic [5:0]  SIX_RECIP  = 6'd43;
  localparam logic [2:0]  SECTORS    = 3'd6;
  // floor(2^32 / 600), underestimates c*t / 600 by at most one
  localparam logic [22:0] RAMP_RECIP = 23'd7158278;
  localparam logic [15:0] FULL_SCALE = 16'hFFFF;

endpackage

// ----- rtl/core/hsv_to_rgb_converter_top.sv -----
// hsv to rgb pixel converter, seven register stages
// throughput: one pixel per cycle unless stalled; the hue and ramp divides by 600 each
// use reciprocal multiply and correction stages, chroma / 65535 folds and corrects
// reset: rst clears the stage valid bits only; the data registers are not reset
module hsv_to_rgb_converter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               hsv_valid,
  output logic               hsv_stall,
  input  hsvrgb_pkg::hsv_t   hsv,
  output logic               rgb_valid,
  input  logic               rgb_stall,
  output hsvrgb_pkg::rgb_t   rgb
);
  import hsvrgb_pkg::*;

  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] rdy;

  // stage ready chain, bubbles are filled
  always_comb begin
    rdy[NSTAGE] = !vld[NSTAGE] || !rgb_stall;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign hsv_stall = !rdy[1];
  assign rgb_valid = vld[NSTAGE];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= hsv_valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: hue / 600 estimate and brightness * saturation
  logic [28:0] hue_prod;
  logic [15:0] s1_hue;
  logic [6:0]  s1_qest;
  logic [31:0] s1_cprod;
  logic [15:0] s1_val;

  assign hue_prod = 29'(hsv.hue) * 29'(HUE_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_hue   <= hsv.hue;
      s1_qest  <= hue_prod[28:22];
      s1_cprod <= 32'(hsv.brightness) * 32'(hsv.saturation);
      s1_val   <= hsv.brightness;
    end
  end

  // stage 2: correct the hue quotient, finish chroma = product / 65535
  logic [15:0] hue_base;
  logic [10:0] hue_rem;
  logic [15:0] cq0;
  logic [16:0] crem;
  logic [6:0]  s2_q;
  logic [9:0]  s2_off;
  logic [15:0] s2_c;
  logic [15:0] s2_val;

  assign hue_base = 16'(s1_qest) * 16'(HUE_SECTOR);
  assign hue_rem  = 11'(s1_hue - hue_base);
  assign cq0      = s1_cprod[31:16];
  assign crem     = {1'b0, s1_cprod[15:0]} + {1'b0, cq0};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      if (hue_rem >= 11'(HUE_SECTOR)) begin
        s2_q   <= s1_qest + 7'd1;
        s2_off <= 10'(hue_rem - 11'(HUE_SECTOR));
      end else begin
        s2_q   <= s1_qest;
        s2_off <= hue_rem[9:0];
      end
      s2_c   <= (crem >= 17'(FULL_SCALE)) ? cq0 + 16'd1 : cq0;
      s2_val <= s1_val;
    end
  end

  // stage 3: sector = quotient mod 6, ramp weight, offset m
  logic [12:0] six_prod;
  logic [6:0]  q_div6;
  logic [2:0]  sec_raw;
  sector_t     s3_sector;
  logic [9:0]  s3_t;
  logic [15:0] s3_c;
  logic [15:0] s3_m;

  assign six_prod = 13'(s2_q) * 13'(SIX_RECIP);
  assign q_div6   = 7'(six_prod >> 8);
  assign sec_raw  = 3'(s2_q - 7'(q_div6 * 7'(SECTORS)));

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_sector <= sector_t'(sec_raw);
      s3_t      <= sec_raw[0] ? HUE_SECTOR - s2_off : s2_off;
      s3_c      <= s2_c;
      s3_m      <= s2_val - s2_c;
    end
  end

  // stage 4: c * t
  logic [25:0] s4_ct;
  sector_t     s4_sector;
  logic [15:0] s4_c;
  logic [15:0] s4_m;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_ct     <= 26'(s3_c) * 26'(s3_t);
      s4_sector <= s3_sector;
      s4_c      <= s3_c;
      s4_m      <= s3_m;
    end
  end

  // stage 5: x estimate by reciprocal multiply
  logic [48:0] ramp_prod;
  logic [15:0] s5_xest;
  logic [25:0] s5_ct;
  sector_t     s5_sector;
  logic [15:0] s5_c;
  logic [15:0] s5_m;

  assign ramp_prod = 49'(s4_ct) * 49'(RAMP_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_xest   <= ramp_prod[47:32];
      s5_ct     <= s4_ct;
      s5_sector <= s4_sector;
      s5_c      <= s4_c;
      s5_m      <= s4_m;
    end
  end

  // stage 6: correct x by one remainder compare
  logic [25:0] ramp_base;
  logic [25:0] ramp_rem;
  logic [15:0] s6_x;
  sector_t     s6_sector;
  logic [15:0] s6_c;
  logic [15:0] s6_m;

  assign ramp_base = 26'(s5_xest) * 26'(HUE_SECTOR);
  assign ramp_rem  = s5_ct - ramp_base;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_x      <= (ramp_rem >= 26'(HUE_SECTOR)) ? s5_xest + 16'd1 : s5_xest;
      s6_sector <= s5_sector;
      s6_c      <= s5_c;
      s6_m      <= s5_m;
    end
  end

  // stage 7: place c and x by sector, add m
  logic [15:0] rp;
  logic [15:0] gp;
  logic [15:0] bp;

  always_comb begin
    case (s6_sector)
      SEC_RED_YEL: begin rp = s6_c;  gp = s6_x;  bp = '0;    end
      SEC_YEL_GRN: begin rp = s6_x;  gp = s6_c;  bp = '0;    end
      SEC_GRN_CYN: begin rp = '0;    gp = s6_c;  bp = s6_x;  end
      SEC_CYN_BLU: begin rp = '0;    gp = s6_x;  bp = s6_c;  end
      SEC_BLU_MAG: begin rp = s6_x;  gp = '0;    bp = s6_c;  end
      default:     begin rp = s6_c;  gp = '0;    bp = s6_x;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      rgb.red   <= rp + s6_m;
      rgb.green <= gp + s6_m;
      rgb.blue  <= bp + s6_m;
    end
  end

  function automatic logic sec_raw_q3_ok(input sector_t s);
    return 3'(s) < SECTORS;
  endfunction

  // hue split stays inside one sector
  a_off_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (s2_off < HUE_SECTOR) && (s2_q <= 7'd109))
    else $error("hue offset or quotient out of range");

  // sector code and ramp weight in range after mod 6
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (sec_raw_q3_ok(s3_sector)) && (s3_t <= HUE_SECTOR))
    else $error("sector or ramp weight out of range");

  // corrected ramp term never exceeds chroma
  a_ramp_le_chroma: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (s6_x <= s6_c))
    else $error("ramp term exceeds chroma");

endmodule
